// ===== rtl/core/hsp_pkg.sv =====
// ----------------------------------------------------------------------------
// hsp_pkg: shared types and constants of the SECDED packet checker
// Payload structs, status codes and the data bit to code position mapping.
// ----------------------------------------------------------------------------
package hsp_pkg;

    localparam int HSP_MAX_BYTES = 16;
    localparam int CNT_W         = 5;

    localparam logic REQ_ENCODE = 1'b0;
    localparam logic REQ_CHECK  = 1'b1;

    localparam logic [2:0] STATUS_OK           = 3'd0;
    localparam logic [2:0] STATUS_SINGLE       = 3'd1;
    localparam logic [2:0] STATUS_DOUBLE       = 3'd2;
    localparam logic [2:0] STATUS_DOUBLE_RANGE = 3'd3;
    localparam logic [2:0] STATUS_CHECK_BIT    = 3'd4;

    // 2^i - 1 for the check bit positions
    localparam logic [7:0] POW_M1 [8] = '{8'd0, 8'd1, 8'd3, 8'd7,
                                          8'd15, 8'd31, 8'd63, 8'd127};

    typedef struct packed {
        logic        req_type;
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [15:0] received_fcs;
    } hsp_in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        last_out;
        logic [15:0] computed_fcs;
        logic [2:0]  status;
        logic [7:0]  error_bit_index;
    } hsp_out_t;

    typedef struct packed {
        logic [15:0]      fcs;
        logic [2:0]       status;
        logic [7:0]       idx;
        logic             flip_en;
        logic [CNT_W-1:0] flip_byte;
        logic [7:0]       flip_mask;
        logic [CNT_W-1:0] cnt;
    } hsp_verdict_t;

    // Code position of one-based data bit k: k plus the number of check
    // positions that lie below it.
    function automatic logic [7:0] data_pos(input logic [7:0] k);
        logic [3:0] t;
        t = '0;
        for (int i = 0; i < 8; i++)
        begin
            if ({1'b0, k} + 9'(i) > {1'b0, POW_M1[i]})
            begin
                t = t + 4'd1;
            end
        end
        return k + {4'b0000, t};
    endfunction

endpackage

// ===== rtl/core/hsp_if.sv =====
// ----------------------------------------------------------------------------
// hsp_if: valid/ready channels of the SECDED packet checker
// One channel for packet bytes in, one for result transactions out.
// ----------------------------------------------------------------------------
interface hsp_in_if;
    logic             valid;
    logic             ready;
    hsp_pkg::hsp_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface hsp_out_if;
    logic              valid;
    logic              ready;
    hsp_pkg::hsp_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/hsp_byte_mem.sv =====
// ----------------------------------------------------------------------------
// hsp_byte_mem: packet byte buffer
// Single write port, single read port, read data registered.
// ----------------------------------------------------------------------------
module hsp_byte_mem #(
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [7:0]        wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]        rd_data
);

    logic [7:0] mem_reg [DEPTH];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/core/hsp_accum.sv =====
// ----------------------------------------------------------------------------
// hsp_accum: per-byte check accumulation
// Counts stored bytes and folds the positions of set data bits into the
// running check word and data parity.
// ----------------------------------------------------------------------------
module hsp_accum #(
    parameter int MAX_BYTES = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      take,
    input  logic [7:0]                data_byte,
    input  logic                      clear,
    output logic                      store_en,
    output logic [hsp_pkg::CNT_W-1:0] count,
    output logic [7:0]                accum,
    output logic                      parity
);
    import hsp_pkg::*;

    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       accum_reg, accum_next;
    logic             parity_reg, parity_next;
    logic [7:0]       pos_xor;
    logic [7:0]       k;

    assign store_en = (count_reg < CNT_W'(MAX_BYTES));

    always_comb
    begin
        pos_xor = '0;
        k       = '0;
        for (int j = 0; j < 8; j++)
        begin
            k = {count_reg, 3'b000} + 8'(j) + 8'd1;
            if (data_byte[7 - j])
            begin
                pos_xor = pos_xor ^ data_pos(k);
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        accum_next  = accum_reg;
        parity_next = parity_reg;
        if (clear)
        begin
            count_next  = '0;
            accum_next  = '0;
            parity_next = 1'b0;
        end
        else if (take && store_en)
        begin
            count_next  = count_reg + CNT_W'(1);
            accum_next  = accum_reg ^ pos_xor;
            parity_next = parity_reg ^ (^data_byte);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            accum_reg  <= '0;
            parity_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            accum_reg  <= accum_next;
            parity_reg <= parity_next;
        end
    end

    assign count  = count_reg;
    assign accum  = accum_reg;
    assign parity = parity_reg;

endmodule

// ===== rtl/core/hsp_syndrome.sv =====
// ----------------------------------------------------------------------------
// hsp_syndrome: FCS build and error judgment
// First step builds the FCS from the accumulated check word, second step
// compares it with the received FCS and locates a single data-bit error.
// ----------------------------------------------------------------------------
module hsp_syndrome (
    input  logic                      clk,
    input  logic                      calc_en,
    input  logic                      judge_en,
    input  logic [hsp_pkg::CNT_W-1:0] count,
    input  logic [7:0]                accum,
    input  logic                      parity,
    input  logic [15:0]               received_fcs,
    output hsp_pkg::hsp_verdict_t     verdict
);
    import hsp_pkg::*;

    // first step
    logic [3:0]       r_reg, r_next;
    logic [7:0]       chk_reg, chk_next;
    logic [15:0]      fcs_reg, fcs_next;
    logic             dpar_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [7:0]       n_in;
    logic [7:0]       chk_mask;
    logic             par;

    always_comb
    begin
        n_in   = {count, 3'b000};
        r_next = 4'd8;
        for (int rr = 7; rr >= 1; rr--)
        begin
            if ((10'd1 << rr) >= {2'b00, n_in} + 10'(rr) + 10'd1)
            begin
                r_next = 4'(rr);
            end
        end
        chk_mask = 8'((9'd1 << r_next) - 9'd1);
        chk_next = accum & chk_mask;
        par      = parity ^ (^chk_next);
        fcs_next = '0;
        for (int i = 0; i < 8; i++)
        begin
            fcs_next[15 - i] = chk_next[i];
        end
        for (int i = 0; i < 9; i++)
        begin
            if (4'(i) == r_next)
            begin
                fcs_next[15 - i] = par;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (calc_en)
        begin
            r_reg    <= r_next;
            chk_reg  <= chk_next;
            fcs_reg  <= fcs_next;
            dpar_reg <= par ^ (^chk_next) ^ 1'b0 ^ (^chk_next) ^ par ^ parity;
            cnt_reg  <= count;
        end
    end

    // second step
    logic [15:0]  mask16;
    logic [15:0]  diff;
    logic [7:0]   syn;
    logic [2:0]   lg;
    logic [7:0]   d;
    logic [7:0]   dm1;
    logic [7:0]   n;
    logic         npar;
    logic         rpar;
    hsp_verdict_t verdict_reg, verdict_next;

    always_comb
    begin
        mask16 = '0;
        for (int i = 0; i < 16; i++)
        begin
            mask16[15 - i] = (4'(i) <= r_reg);
        end
        diff = (fcs_reg ^ received_fcs) & mask16;
        syn  = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (4'(i) < r_reg)
            begin
                syn[i] = diff[15 - i];
            end
        end
        lg = '0;
        for (int i = 0; i < 8; i++)
        begin
            if (syn[i])
            begin
                lg = 3'(i);
            end
        end
        d    = syn - {5'b00000, lg} - 8'd1;
        dm1  = d - 8'd1;
        n    = {cnt_reg, 3'b000};
        npar = dpar_reg ^ 1'b1 ^ (^(chk_reg ^ syn));
        rpar = received_fcs[4'd15 - r_reg];

        verdict_next           = '0;
        verdict_next.fcs       = fcs_reg;
        verdict_next.cnt       = cnt_reg;
        verdict_next.flip_byte = dm1[7:3];
        verdict_next.flip_mask = 8'h80 >> dm1[2:0];
        verdict_next.status    = STATUS_OK;
        if (diff != '0)
        begin
            if ((syn & (syn - 8'd1)) == 8'd0)
            begin
                verdict_next.status = STATUS_CHECK_BIT;
            end
            else
            begin
                verdict_next.idx = d;
                if (d > n)
                begin
                    verdict_next.status = STATUS_DOUBLE_RANGE;
                end
                else if (npar != rpar)
                begin
                    verdict_next.status = STATUS_DOUBLE;
                end
                else
                begin
                    verdict_next.status  = STATUS_SINGLE;
                    verdict_next.flip_en = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (judge_en)
        begin
            verdict_reg <= verdict_next;
        end
    end

    assign verdict = verdict_reg;

endmodule

// ===== rtl/core/hamming_secded_packet_check.sv =====
// ----------------------------------------------------------------------------
// hamming_secded_packet_check: SECDED check word build and repair per packet
// Buffers packet bytes, builds the FCS and corrects a single data-bit error.
// ----------------------------------------------------------------------------
// Usage:
//   byte_ch carries one packet byte per transaction, last_byte on the final
//   one; req_type and received_fcs are taken from that final transaction.
//   Bytes are accepted one per cycle; bytes beyond MAX_BYTES are dropped.
//   After the final byte the block builds the FCS (S_CALC), then the verdict
//   (S_JUDGE), with byte_ch.ready low until the packet's results are issued.
//   Encode: one result transaction, loaded in S_ENC after S_JUDGE.
//   Check: one result per buffered byte, each through a buffer read (S_READ),
//   then an output register load (S_LOAD).
//   A stalled result_ch holds the output register and the readout with it;
//   byte_ch reopens as soon as the final result sits in the output register.
//   Reset clears the byte count, check word, parity and all handshake state;
//   the byte buffer needs no clearing since only bytes of the current packet
//   are read.
// ----------------------------------------------------------------------------
module hamming_secded_packet_check #(
    parameter int MAX_BYTES = hsp_pkg::HSP_MAX_BYTES
) (
    input logic       clk,
    input logic       rst_n,
    hsp_in_if.sink    byte_ch,
    hsp_out_if.source result_ch
);
    import hsp_pkg::*;

    localparam int ADDR_W = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_JUDGE,
        S_ENC,
        S_READ,
        S_LOAD
    } state_t;

    state_t           state_reg, state_next;
    logic             mode_reg, mode_next;
    logic [15:0]      rfcs_reg, rfcs_next;
    logic [CNT_W-1:0] emit_idx_reg, emit_idx_next;
    logic             out_valid_reg, out_valid_next;
    hsp_out_t         out_data_reg, out_data_next;

    logic             in_acc;
    logic             out_free;
    logic             store_en;
    logic [CNT_W-1:0] count;
    logic [7:0]       accum;
    logic             parity;
    logic [7:0]       rd_data;
    logic [7:0]       fix_mask;
    hsp_verdict_t     verdict;

    assign byte_ch.ready = (state_reg == S_IDLE);
    assign in_acc        = byte_ch.valid && byte_ch.ready;
    assign out_free      = !out_valid_reg || result_ch.ready;

    hsp_accum #(
        .MAX_BYTES (MAX_BYTES)
    ) u_accum (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_acc),
        .data_byte (byte_ch.data.data_byte),
        .clear     (state_reg == S_JUDGE),
        .store_en  (store_en),
        .count     (count),
        .accum     (accum),
        .parity    (parity)
    );

    hsp_byte_mem #(
        .DEPTH  (MAX_BYTES),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (in_acc && store_en),
        .wr_addr (count[ADDR_W-1:0]),
        .wr_data (byte_ch.data.data_byte),
        .rd_en   (state_reg == S_READ),
        .rd_addr (emit_idx_reg[ADDR_W-1:0]),
        .rd_data (rd_data)
    );

    hsp_syndrome u_syndrome (
        .clk          (clk),
        .calc_en      (state_reg == S_CALC),
        .judge_en     (state_reg == S_JUDGE),
        .count        (count),
        .accum        (accum),
        .parity       (parity),
        .received_fcs (rfcs_reg),
        .verdict      (verdict)
    );

    // repair the one flagged byte on its way out
    assign fix_mask = (verdict.flip_en && (emit_idx_reg == verdict.flip_byte))
                      ? verdict.flip_mask : 8'h00;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        rfcs_next      = rfcs_reg;
        emit_idx_next  = emit_idx_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    mode_next = byte_ch.data.req_type;
                    rfcs_next = byte_ch.data.received_fcs;
                    if (byte_ch.data.last_byte)
                    begin
                        state_next = S_CALC;
                    end
                end
            end
            S_CALC:
            begin
                state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                emit_idx_next = '0;
                state_next    = (mode_reg == REQ_CHECK) ? S_READ : S_ENC;
            end
            S_ENC:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.out_byte        = 8'h00;
                    out_data_next.last_out        = 1'b1;
                    out_data_next.computed_fcs    = verdict.fcs;
                    out_data_next.status          = STATUS_OK;
                    out_data_next.error_bit_index = 8'h00;
                    state_next                    = S_IDLE;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.out_byte        = rd_data ^ fix_mask;
                    out_data_next.last_out        = (emit_idx_reg + CNT_W'(1) == verdict.cnt);
                    out_data_next.computed_fcs    = verdict.fcs;
                    out_data_next.status          = verdict.status;
                    out_data_next.error_bit_index = verdict.idx;
                    emit_idx_next                 = emit_idx_reg + CNT_W'(1);
                    if (emit_idx_reg + CNT_W'(1) == verdict.cnt)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            mode_reg      <= REQ_ENCODE;
            rfcs_reg      <= '0;
            emit_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            rfcs_reg      <= rfcs_next;
            emit_idx_reg  <= emit_idx_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    assign result_ch.valid = out_valid_reg;
    assign result_ch.data  = out_data_reg;

endmodule
